[design/bjg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjg_pkg: shared types, codes and helpers for the ball joint gap block
// Item layouts, register indexes, microcode word and the control store.
// ----------------------------------------------------------------------------
package bjg_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_TWO_BODIES = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_A_X = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_A_Y = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_A_Z = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_B_X = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_B_Y = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ANCHOR_B_Z = 3'd6;

  // Sequencer
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] STEP_FIN = 5'd21;

  typedef struct packed {
    logic               body_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] gap_x;
    logic signed [31:0] gap_y;
    logic signed [31:0] gap_z;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] addr;
    logic [31:0]        wdata;
  } cfg_item_t;

  // Rounded quaternion products, Q.30 with headroom
  typedef struct packed {
    logic signed [33:0] ww;
    logic signed [33:0] xx;
    logic signed [33:0] yy;
    logic signed [33:0] zz;
    logic signed [33:0] xy;
    logic signed [33:0] wz;
    logic signed [33:0] xz;
    logic signed [33:0] wy;
    logic signed [33:0] yz;
    logic signed [33:0] wx;
  } qprod_t;

  typedef enum logic [2:0] {MA_W, MA_X, MA_Y, MA_Z, MA_E} ma_e;
  typedef enum logic [2:0] {MB_W, MB_X, MB_Y, MB_Z, MB_AX, MB_AY, MB_AZ} mb_e;
  typedef enum logic [3:0] {
    QP_WW, QP_XX, QP_YY, QP_ZZ, QP_XY, QP_WZ, QP_XZ, QP_WY, QP_YZ, QP_WX
  } qp_e;
  typedef enum logic [3:0] {M00, M01, M02, M10, M11, M12, M20, M21, M22} ent_e;
  typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_e;
  typedef enum logic {JMP_NEXT, JMP_SKIP} jmp_e;

  // One control word
  typedef struct packed {
    ma_e              mul_a;
    mb_e              mul_b;
    logic             ent_en;
    ent_e             ent;
    logic             qp_wr;
    qp_e              qp;
    acc_e             acc;
    logic [1:0]       pos_sel;
    logic             wa_wr;
    logic [1:0]       wa_idx;
    jmp_e             jmp;
    logic [StepW-1:0] jmp_tgt;
    logic             fin;
  } ctrl_t;

  // Control store. Products issue one per step; the rounded value lands a
  // step later. Matrix entries are formed in the step before their product.
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      5'd0:  begin
        c.mul_a = MA_W; c.mul_b = MB_W; c.jmp = JMP_SKIP; c.jmp_tgt = STEP_FIN;
      end
      5'd1:  begin c.mul_a = MA_X; c.mul_b = MB_X; c.qp_wr = 1'b1; c.qp = QP_WW; end
      5'd2:  begin c.mul_a = MA_Y; c.mul_b = MB_Y; c.qp_wr = 1'b1; c.qp = QP_XX; end
      5'd3:  begin c.mul_a = MA_Z; c.mul_b = MB_Z; c.qp_wr = 1'b1; c.qp = QP_YY; end
      5'd4:  begin c.mul_a = MA_X; c.mul_b = MB_Y; c.qp_wr = 1'b1; c.qp = QP_ZZ; end
      5'd5:  begin c.mul_a = MA_W; c.mul_b = MB_Z; c.qp_wr = 1'b1; c.qp = QP_XY; end
      5'd6:  begin c.mul_a = MA_X; c.mul_b = MB_Z; c.qp_wr = 1'b1; c.qp = QP_WZ; end
      5'd7:  begin c.mul_a = MA_W; c.mul_b = MB_Y; c.qp_wr = 1'b1; c.qp = QP_XZ; end
      5'd8:  begin c.mul_a = MA_Y; c.mul_b = MB_Z; c.qp_wr = 1'b1; c.qp = QP_WY; end
      5'd9:  begin
        c.mul_a = MA_W; c.mul_b = MB_X; c.qp_wr = 1'b1; c.qp = QP_YZ;
        c.ent_en = 1'b1; c.ent = M00;
      end
      5'd10: begin
        c.mul_a = MA_E; c.mul_b = MB_AX; c.qp_wr = 1'b1; c.qp = QP_WX;
        c.ent_en = 1'b1; c.ent = M01;
      end
      5'd11: begin
        c.mul_a = MA_E; c.mul_b = MB_AY; c.ent_en = 1'b1; c.ent = M02;
        c.acc = ACC_LOAD; c.pos_sel = 2'd0;
      end
      5'd12: begin
        c.mul_a = MA_E; c.mul_b = MB_AZ; c.ent_en = 1'b1; c.ent = M10; c.acc = ACC_ADD;
      end
      5'd13: begin
        c.mul_a = MA_E; c.mul_b = MB_AX; c.ent_en = 1'b1; c.ent = M11; c.acc = ACC_ADD;
      end
      5'd14: begin
        c.mul_a = MA_E; c.mul_b = MB_AY; c.ent_en = 1'b1; c.ent = M12;
        c.acc = ACC_LOAD; c.pos_sel = 2'd1; c.wa_wr = 1'b1; c.wa_idx = 2'd0;
      end
      5'd15: begin
        c.mul_a = MA_E; c.mul_b = MB_AZ; c.ent_en = 1'b1; c.ent = M20; c.acc = ACC_ADD;
      end
      5'd16: begin
        c.mul_a = MA_E; c.mul_b = MB_AX; c.ent_en = 1'b1; c.ent = M21; c.acc = ACC_ADD;
      end
      5'd17: begin
        c.mul_a = MA_E; c.mul_b = MB_AY; c.ent_en = 1'b1; c.ent = M22;
        c.acc = ACC_LOAD; c.pos_sel = 2'd2; c.wa_wr = 1'b1; c.wa_idx = 2'd1;
      end
      5'd18: begin c.mul_a = MA_E; c.mul_b = MB_AZ; c.acc = ACC_ADD; end
      5'd19: begin c.acc = ACC_ADD; end
      5'd20: begin c.wa_wr = 1'b1; c.wa_idx = 2'd2; end
      5'd21: begin c.fin = 1'b1; end
      default: begin c.fin = 1'b1; end
    endcase
    return c;
  endfunction

  // Round half up from Q.60 to Q.30 (or Q.46 to Q.16)
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912;
    return $signed(t[63:30]);
  endfunction

  function automatic logic clip32(input logic signed [35:0] v);
    return (v > 36'sd2147483647) || (v < -36'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [33:0] sat34(input logic signed [35:0] v);
    logic signed [33:0] r;
    if (v > 36'sd8589934591) r = 34'sh1ffffffff;
    else if (v < -36'sd8589934592) r = 34'sh200000000;
    else r = v[33:0];
    return r;
  endfunction

  // Rotation matrix entry from the rounded products, clipped to Q2.30
  function automatic logic signed [31:0] mat_entry(input qprod_t p, input ent_e idx);
    logic signed [35:0] v;
    case (idx)
      M00: v = 36'(p.ww) + 36'(p.xx) - 36'(p.yy) - 36'(p.zz);
      M01: v = (36'(p.xy) - 36'(p.wz)) <<< 1;
      M02: v = (36'(p.xz) + 36'(p.wy)) <<< 1;
      M10: v = (36'(p.xy) + 36'(p.wz)) <<< 1;
      M11: v = 36'(p.ww) - 36'(p.xx) + 36'(p.yy) - 36'(p.zz);
      M12: v = (36'(p.yz) - 36'(p.wx)) <<< 1;
      M20: v = (36'(p.xz) - 36'(p.wy)) <<< 1;
      M21: v = (36'(p.yz) + 36'(p.wx)) <<< 1;
      M22: v = 36'(p.ww) - 36'(p.xx) - 36'(p.yy) + 36'(p.zz);
      default: v = '0;
    endcase
    return sat32(v);
  endfunction

endpackage

[design/bjg_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bjg_stream_if: valid/ready channel
// Carries one item of type T per accepted handshake.
// ----------------------------------------------------------------------------
interface bjg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/ball_joint_gap_residual_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_joint_gap_residual_core: spherical joint gap from body poses
// Microcoded sequencer around one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
// Each pose item (Q16.16 position, Q2.30 quaternion) is turned into a world
// anchor pos + R(q) * anchor, with anchor A for body 0 and anchor B for
// body 1. In two-body mode a body A pose only updates the stored anchor and a
// body B pose yields stored-minus-current; in one-body mode a body A pose
// yields its world anchor minus the fixed world point anchor B (and is stored),
// and body B poses are dropped. Poses are accepted only while the sequencer
// is idle; each passes an accept cycle and then the microcode steps, whose
// length is set by the single multiplier that issues ten quaternion products
// and nine matrix-by-anchor products in sequence. A dropped item jumps from
// the first step to the last. The result sits in an output register, so the
// next pose is taken while it waits; the sequencer holds on its last step
// only if the previous result is still pending. Config writes go to the
// registers at once and are meant for idle periods.
// ----------------------------------------------------------------------------
module ball_joint_gap_residual_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  bjg_stream_if.sink   cfg_i,
  bjg_stream_if.sink   in_i,
  bjg_stream_if.source out_o
);

  // --------------------------------------------------------------------------
  // Config registers
  // --------------------------------------------------------------------------
  logic               two_bodies_q;
  logic signed [31:0] anc_a_q [3];
  logic signed [31:0] anc_b_q [3];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_bodies_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        anc_a_q[i] <= '0;
        anc_b_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      case (cfg_i.data.addr)
        bjg_pkg::REG_TWO_BODIES: two_bodies_q <= cfg_i.data.wdata[0];
        bjg_pkg::REG_ANCHOR_A_X: anc_a_q[0] <= $signed(cfg_i.data.wdata);
        bjg_pkg::REG_ANCHOR_A_Y: anc_a_q[1] <= $signed(cfg_i.data.wdata);
        bjg_pkg::REG_ANCHOR_A_Z: anc_a_q[2] <= $signed(cfg_i.data.wdata);
        bjg_pkg::REG_ANCHOR_B_X: anc_b_q[0] <= $signed(cfg_i.data.wdata);
        bjg_pkg::REG_ANCHOR_B_Y: anc_b_q[1] <= $signed(cfg_i.data.wdata);
        bjg_pkg::REG_ANCHOR_B_Z: anc_b_q[2] <= $signed(cfg_i.data.wdata);
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: step counter, control store, conditional skip
  // --------------------------------------------------------------------------
  logic                       busy_q;
  logic [bjg_pkg::StepW-1:0]  step_q;
  bjg_pkg::ctrl_t             ctrl;
  logic                       in_acc;
  logic                       has_res;  // this item yields a result
  logic                       skip;     // body B in one-body mode
  logic                       stall;    // result ready, output still held
  logic                       fin_go;   // last step completes this cycle
  logic                       out_valid_q;

  // Captured pose
  logic                       body_q;
  logic signed [31:0]         pos_q [3];
  logic signed [31:0]         qw_q, qx_q, qy_q, qz_q;

  assign ctrl    = bjg_pkg::ucode(step_q);
  assign in_acc  = in_i.valid && in_i.ready;
  assign in_i.ready = !busy_q;
  assign has_res = (body_q == two_bodies_q);
  assign skip    = body_q && !two_bodies_q;
  assign stall   = ctrl.fin && has_res && out_valid_q && !out_o.ready;
  assign fin_go  = busy_q && ctrl.fin && !stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (!busy_q) begin
      if (in_acc) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end
    end else if (ctrl.fin) begin
      if (!stall) busy_q <= 1'b0;
    end else if (ctrl.jmp == bjg_pkg::JMP_SKIP && skip) begin
      step_q <= ctrl.jmp_tgt;
    end else begin
      step_q <= step_q + bjg_pkg::StepW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      body_q   <= in_i.data.body_index;
      pos_q[0] <= in_i.data.pos_x;
      pos_q[1] <= in_i.data.pos_y;
      pos_q[2] <= in_i.data.pos_z;
      qw_q     <= in_i.data.quat_w;
      qx_q     <= in_i.data.quat_x;
      qy_q     <= in_i.data.quat_y;
      qz_q     <= in_i.data.quat_z;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: operand muxes, shared multiplier, rounding, product store,
  // entry former, accumulator, world anchor registers
  // --------------------------------------------------------------------------
  logic signed [31:0] op_a, op_b;
  logic signed [31:0] e_q;
  logic signed [63:0] prod_q;
  logic signed [33:0] rnd;
  bjg_pkg::qprod_t    qp_q;
  logic signed [35:0] acc_q;
  logic signed [33:0] wa_q  [3];  // current pose's world anchor
  logic signed [33:0] fwa_q [3];  // stored body A world anchor

  // Anchor of the body being processed
  logic signed [31:0] anc_sel [3];
  always_comb begin
    for (int i = 0; i < 3; i++) anc_sel[i] = body_q ? anc_b_q[i] : anc_a_q[i];
  end

  always_comb begin
    case (ctrl.mul_a)
      bjg_pkg::MA_W: op_a = qw_q;
      bjg_pkg::MA_X: op_a = qx_q;
      bjg_pkg::MA_Y: op_a = qy_q;
      bjg_pkg::MA_Z: op_a = qz_q;
      bjg_pkg::MA_E: op_a = e_q;
      default:       op_a = '0;
    endcase
    case (ctrl.mul_b)
      bjg_pkg::MB_W:  op_b = qw_q;
      bjg_pkg::MB_X:  op_b = qx_q;
      bjg_pkg::MB_Y:  op_b = qy_q;
      bjg_pkg::MB_Z:  op_b = qz_q;
      bjg_pkg::MB_AX: op_b = anc_sel[0];
      bjg_pkg::MB_AY: op_b = anc_sel[1];
      bjg_pkg::MB_AZ: op_b = anc_sel[2];
      default:        op_b = '0;
    endcase
  end

  assign rnd = bjg_pkg::rnd30(prod_q);

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      prod_q <= 64'(op_a) * 64'(op_b);
      if (ctrl.ent_en) e_q <= bjg_pkg::mat_entry(qp_q, ctrl.ent);
      if (ctrl.qp_wr) begin
        case (ctrl.qp)
          bjg_pkg::QP_WW: qp_q.ww <= rnd;
          bjg_pkg::QP_XX: qp_q.xx <= rnd;
          bjg_pkg::QP_YY: qp_q.yy <= rnd;
          bjg_pkg::QP_ZZ: qp_q.zz <= rnd;
          bjg_pkg::QP_XY: qp_q.xy <= rnd;
          bjg_pkg::QP_WZ: qp_q.wz <= rnd;
          bjg_pkg::QP_XZ: qp_q.xz <= rnd;
          bjg_pkg::QP_WY: qp_q.wy <= rnd;
          bjg_pkg::QP_YZ: qp_q.yz <= rnd;
          bjg_pkg::QP_WX: qp_q.wx <= rnd;
          default: ;
        endcase
      end
      case (ctrl.acc)
        bjg_pkg::ACC_LOAD: acc_q <= 36'(pos_q[ctrl.pos_sel]) + 36'(rnd);
        bjg_pkg::ACC_ADD:  acc_q <= acc_q + 36'(rnd);
        default: ;
      endcase
      if (ctrl.wa_wr) wa_q[ctrl.wa_idx] <= bjg_pkg::sat34(acc_q);
    end
  end

  // Stored anchor: body A poses only, in either mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) fwa_q[i] <= '0;
    end else if (fin_go && !body_q) begin
      for (int i = 0; i < 3; i++) fwa_q[i] <= wa_q[i];
    end
  end

  // --------------------------------------------------------------------------
  // Gap and output register
  // --------------------------------------------------------------------------
  logic signed [35:0] diff [3];
  logic signed [31:0] gap  [3];
  logic               clip;
  logic signed [31:0] gap_q [3];
  logic               sat_q;

  always_comb begin
    clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (body_q) diff[i] = 36'(fwa_q[i]) - 36'(wa_q[i]);
      else        diff[i] = 36'(wa_q[i]) - 36'(anc_b_q[i]);
      gap[i] = bjg_pkg::sat32(diff[i]);
      clip   = clip | bjg_pkg::clip32(diff[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_go && has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_go && has_res) begin
      for (int i = 0; i < 3; i++) gap_q[i] <= gap[i];
      sat_q <= clip;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.data.gap_x     = gap_q[0];
  assign out_o.data.gap_y     = gap_q[1];
  assign out_o.data.gap_z     = gap_q[2];
  assign out_o.data.saturated = sat_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (step_q <= bjg_pkg::STEP_FIN))
    else $error("step counter past last step");

  a_res_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(busy_q && ctrl.fin))
    else $error("result raised outside last step");

  a_store_body_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable({fwa_q[0], fwa_q[1], fwa_q[2]}) |-> $past(fin_go && !body_q))
    else $error("stored anchor changed outside a body A item");

  a_drop_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && ctrl.fin && skip && !out_valid_q) |=> !out_valid_q)
    else $error("dropped item produced a result");

endmodule
